// ----- sv/multi_key_sorted_table_top_assert.svh -----
// Assertion macros for the sorted key table checker.
// Used by the checker only; needs no other file.
`ifndef MULTI_KEY_SORTED_TABLE_TOP_ASSERT_SVH
`define MULTI_KEY_SORTED_TABLE_TOP_ASSERT_SVH

// same-cycle implication
`define MKST_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("mkst same-cycle check failed");

// next-cycle implication
`define MKST_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("mkst next-cycle check failed");

`endif

// ----- sv/mkst_pkg.sv -----
// Shared types, widths and operation codes for the sorted key table.
// No dependencies.
package mkst_pkg;

	localparam int MAX_RECORDS = 64;
	localparam int PAYLOAD_W   = 64;
	localparam int KEY_W       = 32;
	localparam int NUM_KEYS    = 4;
	localparam int IDX_W       = $clog2(MAX_RECORDS);
	localparam int CNT_W       = $clog2(MAX_RECORDS + 1);
	localparam int PORT_IDX_W  = 6;
	localparam int PORT_CNT_W  = 7;
	localparam int KIND_W      = 4;
	localparam int CRIT_W      = 4;
	localparam int REL_W       = 2;
	localparam int PK_W        = 2;
	localparam int KN_W        = 3;

	localparam logic [KIND_W-1:0] KIND_INSERT = 4'd0;
	localparam logic [KIND_W-1:0] KIND_UPDATE = 4'd1;
	localparam logic [KIND_W-1:0] KIND_DELETE = 4'd2;
	localparam logic [KIND_W-1:0] KIND_QKEY   = 4'd3;
	localparam logic [KIND_W-1:0] KIND_QIDX   = 4'd4;
	localparam logic [KIND_W-1:0] KIND_FIND   = 4'd5;
	localparam logic [KIND_W-1:0] KIND_REL    = 4'd6;
	localparam logic [KIND_W-1:0] KIND_RANGE  = 4'd7;
	localparam logic [KIND_W-1:0] KIND_CLEAR  = 4'd8;

	localparam logic [REL_W-1:0] REL_EQUAL   = 2'd0;
	localparam logic [REL_W-1:0] REL_GREATER = 2'd1;

	localparam logic [CRIT_W-1:0] CRIT_RESET = 4'd15;

	typedef logic [KEY_W-1:0] key_t;
	typedef key_t [NUM_KEYS-1:0] keyset_t;

	typedef struct packed {
		logic [PAYLOAD_W-1:0] payload;
		keyset_t              keys;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef struct packed {
		logic             rd_en;
		logic [IDX_W-1:0] rd_addr;
		logic             wr_en;
		logic [IDX_W-1:0] wr_addr;
		entry_t           wr_data;
	} ram_req_t;

	typedef struct packed {
		logic [KIND_W-1:0]     kind;
		keyset_t               keys;
		logic [PAYLOAD_W-1:0]  payload;
		logic [PORT_IDX_W-1:0] eidx;
		logic [REL_W-1:0]      rel;
		logic [PK_W-1:0]       pk;
	} cmd_t;

	typedef struct packed {
		logic                 ok;
		logic [IDX_W-1:0]     first;
		logic [IDX_W-1:0]     last;
		logic [PAYLOAD_W-1:0] pay;
	} result_t;

	typedef struct packed {
		logic lt;
		logic eq;
	} cmp_t;

	// count of leading set criteria bits
	function automatic logic [KN_W-1:0] active_keys(input logic [CRIT_W-1:0] crit);
		logic [KN_W-1:0] n;
		if (!crit[0])
			n = 3'd0;
		else if (!crit[1])
			n = 3'd1;
		else if (!crit[2])
			n = 3'd2;
		else if (!crit[3])
			n = 3'd3;
		else
			n = 3'd4;
		return n;
	endfunction

endpackage

// ----- sv/mkst_ram.sv -----
// Generic simple dual-port RAM with registered read.
// No dependencies.
module mkst_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
	end

	always_ff @(posedge clk) begin
		if (rd_en)
			rd_data <= mem[rd_addr];
	end

endmodule

// ----- sv/mkst_cmp.sv -----
// Lexicographic key compare: entry below search keys, and equality over a prefix.
// Depends on mkst_pkg.
module mkst_cmp (
	input  mkst_pkg::keyset_t           entry_keys,
	input  mkst_pkg::keyset_t           search_keys,
	input  logic [mkst_pkg::KN_W-1:0]   order_keys,
	input  logic [mkst_pkg::KN_W-1:0]   match_keys,
	output mkst_pkg::cmp_t              res
);

	logic decided;

	always_comb begin
		decided = 1'b0;
		res.lt  = 1'b0;
		res.eq  = 1'b1;
		for (int i = 0; i < mkst_pkg::NUM_KEYS; i++) begin
			if (mkst_pkg::KN_W'(i) < order_keys && !decided) begin
				if (entry_keys[i] < search_keys[i]) begin
					res.lt  = 1'b1;
					decided = 1'b1;
				end else if (entry_keys[i] > search_keys[i]) begin
					decided = 1'b1;
				end
			end
			if (mkst_pkg::KN_W'(i) < match_keys && entry_keys[i] != search_keys[i])
				res.eq = 1'b0;
		end
	end

endmodule

// ----- sv/mkst_seq.sv -----
// Operation sequencer: scans the entry RAM, then shifts entries up or down.
// Depends on mkst_pkg and mkst_cmp.
module mkst_seq (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  mkst_pkg::cmd_t                  cmd,
	input  logic [mkst_pkg::CRIT_W-1:0]     criteria,
	output logic                            idle,
	output mkst_pkg::ram_req_t              ram_req,
	input  mkst_pkg::entry_t                ram_rdata,
	output logic                            res_valid,
	input  logic                            res_take,
	output mkst_pkg::result_t               res,
	output logic [mkst_pkg::CNT_W-1:0]      fill
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_SCAN = 3'd1;
	localparam logic [2:0] S_SHUP = 3'd2;
	localparam logic [2:0] S_SHDN = 3'd3;
	localparam logic [2:0] S_PUT  = 3'd4;
	localparam logic [2:0] S_IRD  = 3'd5;
	localparam logic [2:0] S_ICAP = 3'd6;
	localparam logic [2:0] S_DONE = 3'd7;

	localparam int IW = mkst_pkg::IDX_W;
	localparam int CW = mkst_pkg::CNT_W;

	logic [2:0]                     state_q;
	mkst_pkg::cmd_t                 cmd_q;
	logic [mkst_pkg::KN_W-1:0]      n_q;
	logic [mkst_pkg::KN_W-1:0]      k_q;
	logic [CW-1:0]                  fill_q;
	logic [CW-1:0]                  rd_q;
	logic                           v_s1;
	logic [IW-1:0]                  idx_s1;
	logic                           lb_found_q;
	logic [CW-1:0]                  lb_q;
	logic                           lb2_found_q;
	logic [CW-1:0]                  lb2_q;
	logic                           ff_found_q;
	logic [IW-1:0]                  ff_q;
	logic                           run_q;
	logic [IW-1:0]                  last_q;
	logic [mkst_pkg::PAYLOAD_W-1:0] fpay_q;
	logic [CW-1:0]                  sh_q;
	logic [CW-1:0]                  lim_q;
	logic [IW-1:0]                  bot_q;
	logic                           mv_s1;
	logic [IW-1:0]                  dst_s1;
	mkst_pkg::result_t              res_q;
	mkst_pkg::cmp_t                 cmp;
	logic [mkst_pkg::KN_W-1:0]      n_new;
	logic [mkst_pkg::KN_W-1:0]      pk_ext;
	logic                           up_more;
	logic                           dn_more;

	mkst_cmp u_cmp (
		.entry_keys  (ram_rdata.keys),
		.search_keys (cmd_q.keys),
		.order_keys  (n_q),
		.match_keys  (k_q),
		.res         (cmp)
	);

	assign n_new   = mkst_pkg::active_keys(criteria);
	assign pk_ext  = mkst_pkg::KN_W'(cmd.pk);
	assign up_more = sh_q > CW'(bot_q);
	assign dn_more = (sh_q + 1'b1) < lim_q;

	assign idle      = (state_q == S_IDLE);
	assign res_valid = (state_q == S_DONE);
	assign res       = res_q;
	assign fill      = fill_q;

	always_comb begin
		ram_req         = '0;
		ram_req.wr_data = mkst_pkg::entry_t'({cmd_q.payload, cmd_q.keys});
		unique case (state_q)
			S_SCAN: begin
				ram_req.rd_en   = rd_q < fill_q;
				ram_req.rd_addr = rd_q[IW-1:0];
			end
			S_SHUP: begin
				ram_req.rd_en   = up_more;
				ram_req.rd_addr = IW'(sh_q - 1'b1);
			end
			S_SHDN: begin
				ram_req.rd_en   = dn_more;
				ram_req.rd_addr = IW'(sh_q + 1'b1);
			end
			S_IRD: begin
				ram_req.rd_en   = 1'b1;
				ram_req.rd_addr = IW'(cmd_q.eidx);
			end
			S_PUT: begin
				ram_req.wr_en   = 1'b1;
				ram_req.wr_addr = bot_q;
			end
			default: begin
			end
		endcase
		// move the entry read last cycle
		if (mv_s1 && (state_q == S_SHUP || state_q == S_SHDN)) begin
			ram_req.wr_en   = 1'b1;
			ram_req.wr_addr = dst_s1;
			ram_req.wr_data = ram_rdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cmd_q       <= '0;
			n_q         <= '0;
			k_q         <= '0;
			fill_q      <= '0;
			rd_q        <= '0;
			v_s1        <= 1'b0;
			idx_s1      <= '0;
			lb_found_q  <= 1'b0;
			lb_q        <= '0;
			lb2_found_q <= 1'b0;
			lb2_q       <= '0;
			ff_found_q  <= 1'b0;
			ff_q        <= '0;
			run_q       <= 1'b0;
			last_q      <= '0;
			fpay_q      <= '0;
			sh_q        <= '0;
			lim_q       <= '0;
			bot_q       <= '0;
			mv_s1       <= 1'b0;
			dst_s1      <= '0;
			res_q       <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						cmd_q       <= cmd;
						n_q         <= n_new;
						k_q         <= (cmd.kind == mkst_pkg::KIND_RANGE && pk_ext < n_new)
							? pk_ext : n_new;
						res_q       <= '0;
						rd_q        <= '0;
						v_s1        <= 1'b0;
						mv_s1       <= 1'b0;
						lb_found_q  <= 1'b0;
						lb_q        <= fill_q;
						lb2_found_q <= 1'b0;
						lb2_q       <= fill_q;
						ff_found_q  <= 1'b0;
						run_q       <= 1'b0;
						priority case (1'b1)
							cmd.kind == mkst_pkg::KIND_CLEAR: begin
								fill_q    <= '0;
								res_q.ok  <= 1'b1;
								state_q   <= S_DONE;
							end
							cmd.kind == mkst_pkg::KIND_QIDX: begin
								state_q <= (CW'(cmd.eidx) < fill_q) ? S_IRD : S_DONE;
							end
							cmd.kind > mkst_pkg::KIND_CLEAR: state_q <= S_DONE;
							n_new == '0: state_q <= S_DONE;
							cmd.kind == mkst_pkg::KIND_INSERT
								&& fill_q == CW'(mkst_pkg::MAX_RECORDS): state_q <= S_DONE;
							cmd.kind == mkst_pkg::KIND_RANGE && cmd.pk == '0:
								state_q <= S_DONE;
							default: state_q <= S_SCAN;
						endcase
					end
				end
				S_SCAN: begin
					v_s1   <= rd_q < fill_q;
					idx_s1 <= rd_q[IW-1:0];
					if (rd_q < fill_q)
						rd_q <= rd_q + 1'b1;
					if (v_s1) begin
						if (!lb_found_q && !cmp.lt) begin
							lb_found_q <= 1'b1;
							lb_q       <= CW'(idx_s1);
						end
						// insert position once the first match is taken out
						if (ff_found_q && !lb2_found_q && !cmp.lt) begin
							lb2_found_q <= 1'b1;
							lb2_q       <= CW'(idx_s1);
						end
						if (!ff_found_q && cmp.eq) begin
							ff_found_q <= 1'b1;
							ff_q       <= idx_s1;
							last_q     <= idx_s1;
							run_q      <= 1'b1;
							fpay_q     <= ram_rdata.payload;
						end else if (run_q) begin
							if (cmp.eq)
								last_q <= idx_s1;
							else
								run_q <= 1'b0;
						end
					end
					if (rd_q == fill_q && !v_s1) begin
						unique case (cmd_q.kind)
							mkst_pkg::KIND_INSERT: begin
								sh_q        <= fill_q;
								bot_q       <= lb_q[IW-1:0];
								res_q.ok    <= 1'b1;
								res_q.first <= lb_q[IW-1:0];
								state_q     <= S_SHUP;
							end
							mkst_pkg::KIND_UPDATE: begin
								sh_q     <= CW'(ff_q);
								lim_q    <= lb2_q;
								res_q.ok <= ff_found_q;
								if (!ff_found_q) begin
									res_q.first <= '0;
									state_q     <= S_DONE;
								end else if (lb_q < CW'(ff_q)) begin
									bot_q       <= lb_q[IW-1:0];
									res_q.first <= lb_q[IW-1:0];
									state_q     <= S_SHUP;
								end else begin
									// new slot lies after the removed one: pull entries down
									bot_q       <= IW'(lb2_q - 1'b1);
									res_q.first <= IW'(lb2_q - 1'b1);
									state_q     <= S_SHDN;
								end
							end
							mkst_pkg::KIND_DELETE: begin
								sh_q        <= CW'(ff_q);
								lim_q       <= fill_q;
								res_q.ok    <= ff_found_q;
								res_q.first <= ff_found_q ? ff_q : '0;
								state_q     <= ff_found_q ? S_SHDN : S_DONE;
							end
							mkst_pkg::KIND_QKEY: begin
								res_q.ok    <= ff_found_q;
								res_q.first <= ff_found_q ? ff_q : '0;
								res_q.pay   <= ff_found_q ? fpay_q : '0;
								state_q     <= S_DONE;
							end
							mkst_pkg::KIND_FIND: begin
								res_q.ok    <= ff_found_q;
								res_q.first <= ff_found_q ? ff_q : '0;
								state_q     <= S_DONE;
							end
							mkst_pkg::KIND_REL: begin
								priority if (cmd_q.rel == mkst_pkg::REL_EQUAL) begin
									res_q.ok    <= ff_found_q;
									res_q.first <= ff_found_q ? ff_q : '0;
								end else if (cmd_q.rel == mkst_pkg::REL_GREATER) begin
									res_q.ok    <= lb_q != '0;
									res_q.first <= (lb_q != '0) ? IW'(lb_q - 1'b1) : '0;
								end else begin
									res_q.ok    <= lb_q < fill_q;
									res_q.first <= (lb_q < fill_q) ? lb_q[IW-1:0] : '0;
								end
								state_q <= S_DONE;
							end
							mkst_pkg::KIND_RANGE: begin
								res_q.ok    <= ff_found_q;
								res_q.first <= ff_found_q ? ff_q : '0;
								res_q.last  <= ff_found_q ? last_q : '0;
								state_q     <= S_DONE;
							end
							default: state_q <= S_DONE;
						endcase
					end
				end
				S_SHUP: begin
					mv_s1  <= up_more;
					dst_s1 <= sh_q[IW-1:0];
					if (up_more)
						sh_q <= sh_q - 1'b1;
					else if (!mv_s1)
						state_q <= S_PUT;
				end
				S_SHDN: begin
					mv_s1  <= dn_more;
					dst_s1 <= sh_q[IW-1:0];
					if (dn_more) begin
						sh_q <= sh_q + 1'b1;
					end else if (!mv_s1) begin
						if (cmd_q.kind == mkst_pkg::KIND_UPDATE) begin
							state_q <= S_PUT;
						end else begin
							fill_q  <= fill_q - 1'b1;
							state_q <= S_DONE;
						end
					end
				end
				S_PUT: begin
					if (cmd_q.kind == mkst_pkg::KIND_INSERT)
						fill_q <= fill_q + 1'b1;
					state_q <= S_DONE;
				end
				S_IRD: state_q <= S_ICAP;
				S_ICAP: begin
					res_q.ok    <= 1'b1;
					res_q.first <= IW'(cmd_q.eidx);
					res_q.pay   <= ram_rdata.payload;
					state_q     <= S_DONE;
				end
				S_DONE: begin
					if (res_take)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ----- sv/multi_key_sorted_table_top.sv -----
// Channel   | handshake            | payload
// input     | in_valid / in_ready  | kind, four keys, payload_in, entry_index, relation, prefix_keys
// result    | out_valid / out_ready| success, first_index, last_index, payload_out, entry_count
// config    | cfg_wr_en            | cfg_wr_data (key criteria)
// One item at a time. A key operation scans all stored entries at one RAM read per
// cycle, then insert/update/delete move one entry per cycle through the single RAM
// write port. Query on index reads its one entry directly, with no scan.
// Reset empties the table and sets criteria to 15; RAM contents are not cleared.
// A result waits in the output register; the next item is taken meanwhile.
// Depends on mkst_pkg, mkst_ram, mkst_seq.
module multi_key_sorted_table_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [mkst_pkg::KIND_W-1:0]         kind,
	input  logic [mkst_pkg::KEY_W-1:0]          key_primary,
	input  logic [mkst_pkg::KEY_W-1:0]          key_secondary,
	input  logic [mkst_pkg::KEY_W-1:0]          key_tertiary,
	input  logic [mkst_pkg::KEY_W-1:0]          key_quaternary,
	input  logic [mkst_pkg::PAYLOAD_W-1:0]      payload_in,
	input  logic [mkst_pkg::PORT_IDX_W-1:0]     entry_index,
	input  logic [mkst_pkg::REL_W-1:0]          relation,
	input  logic [mkst_pkg::PK_W-1:0]           prefix_keys,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic                                success,
	output logic [mkst_pkg::PORT_IDX_W-1:0]     first_index,
	output logic [mkst_pkg::PORT_IDX_W-1:0]     last_index,
	output logic [mkst_pkg::PAYLOAD_W-1:0]      payload_out,
	output logic [mkst_pkg::PORT_CNT_W-1:0]     entry_count,
	input  logic                                cfg_wr_en,
	input  logic [mkst_pkg::CRIT_W-1:0]         cfg_wr_data
);

	logic [mkst_pkg::CRIT_W-1:0]  criteria_q;
	logic                         out_valid_q;
	mkst_pkg::cmd_t               cmd;
	mkst_pkg::ram_req_t           ram_req;
	logic [mkst_pkg::ENTRY_W-1:0] ram_rdata;
	logic                         seq_idle;
	logic                         res_valid;
	logic                         res_take;
	mkst_pkg::result_t            res;
	logic [mkst_pkg::CNT_W-1:0]   fill;

	assign cmd.kind    = kind;
	assign cmd.keys    = {key_quaternary, key_tertiary, key_secondary, key_primary};
	assign cmd.payload = payload_in;
	assign cmd.eidx    = entry_index;
	assign cmd.rel     = relation;
	assign cmd.pk      = prefix_keys;

	assign in_ready  = seq_idle;
	assign res_take  = res_valid && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			criteria_q <= mkst_pkg::CRIT_RESET;
		else if (cfg_wr_en)
			criteria_q <= cfg_wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			success     <= 1'b0;
			first_index <= '0;
			last_index  <= '0;
			payload_out <= '0;
			entry_count <= '0;
		end else if (res_take) begin
			out_valid_q <= 1'b1;
			success     <= res.ok;
			first_index <= mkst_pkg::PORT_IDX_W'(res.first);
			last_index  <= mkst_pkg::PORT_IDX_W'(res.last);
			payload_out <= res.pay;
			entry_count <= mkst_pkg::PORT_CNT_W'(fill);
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	mkst_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (in_valid && seq_idle),
		.cmd       (cmd),
		.criteria  (criteria_q),
		.idle      (seq_idle),
		.ram_req   (ram_req),
		.ram_rdata (mkst_pkg::entry_t'(ram_rdata)),
		.res_valid (res_valid),
		.res_take  (res_take),
		.res       (res),
		.fill      (fill)
	);

	mkst_ram #(
		.WIDTH (mkst_pkg::ENTRY_W),
		.DEPTH (mkst_pkg::MAX_RECORDS)
	) u_ram (
		.clk     (clk),
		.rd_en   (ram_req.rd_en),
		.rd_addr (ram_req.rd_addr),
		.rd_data (ram_rdata),
		.wr_en   (ram_req.wr_en),
		.wr_addr (ram_req.wr_addr),
		.wr_data (ram_req.wr_data)
	);

endmodule

// ----- sv/mkst_checker.sv -----
// Port-level checks on the sorted key table, bound to the top level.
// Depends on mkst_pkg and multi_key_sorted_table_top_assert.svh.
`include "multi_key_sorted_table_top_assert.svh"

module mkst_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                out_valid,
	input logic                                out_ready,
	input logic                                success,
	input logic [mkst_pkg::PORT_IDX_W-1:0]     first_index,
	input logic [mkst_pkg::PORT_IDX_W-1:0]     last_index,
	input logic [mkst_pkg::PAYLOAD_W-1:0]      payload_out,
	input logic [mkst_pkg::PORT_CNT_W-1:0]     entry_count
);

	`MKST_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid)
	`MKST_ASSERT_NOW(a_count_max, clk, arst_n, out_valid, entry_count <= mkst_pkg::PORT_CNT_W'(mkst_pkg::MAX_RECORDS))
	`MKST_ASSERT_NOW(a_fail_zero, clk, arst_n, out_valid && !success, first_index == '0 && last_index == '0 && payload_out == '0)
	`MKST_ASSERT_NOW(a_range_order, clk, arst_n, out_valid && last_index != '0, success && last_index >= first_index)

endmodule

bind multi_key_sorted_table_top mkst_checker u_mkst_checker (.*);
